[design/roi_pkg.sv]
// Shared types and constants for the rectangle mask: commands and the beat moved down the cell chain.
package roi_pkg;

    localparam int DIM_W = 13;

    localparam logic [DIM_W-1:0] COLS_RESET = 13'd640;
    localparam logic [DIM_W-1:0] ROWS_RESET = 13'd480;

    // configuration register indexes (word address bit 2)
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // CMD_NONE also marks an empty chain slot
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // done: add already stored upstream, or query pixel outside the image
    typedef struct packed {
        cmd_t             kind;
        logic             done;
        logic             hit;
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] bottom;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
    } beat_t;

endpackage

[design/roi_entry.sv]
// Entry stage: checks rectangles and pixel bounds and registers the first beat of the chain.
module roi_entry
    import roi_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  logic                    load,
    input  logic [1:0]              command,
    input  logic signed [12:0]      rect_left,
    input  logic signed [12:0]      rect_top,
    input  logic signed [13:0]      rect_width,
    input  logic signed [13:0]      rect_height,
    input  logic [COORD_BITS-1:0]   pixel_row,
    input  logic [COORD_BITS-1:0]   pixel_column,
    input  logic [DIM_W-1:0]        image_columns,
    input  logic [DIM_W-1:0]        image_rows,
    output beat_t                   beat
);

    localparam int CW = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

    logic              left_ok;
    logic              top_ok;
    logic              size_ok;
    logic [DIM_W:0]    right_sum;
    logic [DIM_W:0]    bottom_sum;
    logic              end_ok;
    logic              pixel_in;
    beat_t             beat_next;
    beat_t             beat_reg;

    always_comb begin
        left_ok  = !rect_left[12] && ({1'b0, rect_left[11:0]} < image_columns);
        top_ok   = !rect_top[12] && ({1'b0, rect_top[11:0]} < image_rows);
        size_ok  = !rect_width[13] && (rect_width != '0)
                && !rect_height[13] && (rect_height != '0);
        // origin is nonnegative here, so unsigned sums are exact
        right_sum  = {2'b00, rect_left[11:0]} + rect_width[13:0];
        bottom_sum = {2'b00, rect_top[11:0]} + rect_height[13:0];
        end_ok   = (right_sum <= {1'b0, image_columns}) && (bottom_sum <= {1'b0, image_rows});
        pixel_in = (CW'(pixel_row) < CW'(image_rows)) && (CW'(pixel_column) < CW'(image_columns));

        beat_next.kind   = load ? cmd_t'(command) : CMD_NONE;
        beat_next.done   = 1'b0;
        beat_next.hit    = 1'b0;
        beat_next.left   = {1'b0, rect_left[11:0]};
        beat_next.top    = {1'b0, rect_top[11:0]};
        beat_next.right  = right_sum[DIM_W-1:0];
        beat_next.bottom = bottom_sum[DIM_W-1:0];
        // an in-image pixel is below a 13-bit bound, so truncation is safe
        beat_next.col    = DIM_W'(pixel_column);
        beat_next.row    = DIM_W'(pixel_row);

        if (beat_next.kind == CMD_ADD && !(left_ok && top_ok && size_ok && end_ok)) begin
            beat_next.kind = CMD_NONE;
        end
        if (beat_next.kind == CMD_QUERY && !pixel_in) begin
            beat_next.done = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.kind <= CMD_NONE;
        end else if (advance) begin
            beat_reg <= beat_next;
        end
    end

    assign beat = beat_reg;

endmodule

[design/roi_cell.sv]
// One chain cell: holds one rectangle slot and passes each beat on to the next cell.
module roi_cell
    import roi_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  advance,
    input  beat_t beat_in,
    output beat_t beat_out
);

    logic              valid_reg;
    logic [DIM_W-1:0]  left_reg;
    logic [DIM_W-1:0]  top_reg;
    logic [DIM_W-1:0]  right_reg;
    logic [DIM_W-1:0]  bottom_reg;
    beat_t             beat_reg;
    beat_t             beat_next;
    logic              in_rect;
    logic              store;

    always_comb begin
        in_rect = valid_reg
               && (beat_in.col >= left_reg) && (beat_in.col < right_reg)
               && (beat_in.row >= top_reg) && (beat_in.row < bottom_reg);
        // first free slot along the chain takes the rectangle
        store   = (beat_in.kind == CMD_ADD) && !beat_in.done && !valid_reg;

        beat_next = beat_in;
        if (store) begin
            beat_next.done = 1'b1;
        end
        if (beat_in.kind == CMD_QUERY && !beat_in.done && in_rect) begin
            beat_next.hit = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            beat_reg.kind <= CMD_NONE;
        end else if (advance) begin
            beat_reg <= beat_next;
            unique case (beat_in.kind)
                CMD_CLEAR: begin
                    valid_reg <= 1'b0;
                end
                CMD_ADD: begin
                    if (store) begin
                        valid_reg  <= 1'b1;
                        left_reg   <= beat_in.left;
                        top_reg    <= beat_in.top;
                        right_reg  <= beat_in.right;
                        bottom_reg <= beat_in.bottom;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign beat_out = beat_reg;

endmodule

[design/roi_rectangle_mask.sv]
// Top level of the rectangle mask: configuration port, cell chain and result register.
// Every beat (clear, add, query) enters an entry stage and then walks a chain of MAX_RECTS
// cells, one cell per clock unless stalled, each cell holding one rectangle slot; adds land
// in the first free cell, clears empty each cell as they pass, queries collect a hit flag.
// One beat is accepted per clock unless stalled, and a query's result is presented on
// m_tvalid after passing the entry register, the MAX_RECTS cells and the result register.
// While a result waits unread in the output register the whole chain stalls and s_tready
// is low. Configuration changes take effect for beats accepted after the write.
module roi_rectangle_mask
    import roi_pkg::*;
#(
    parameter int MAX_RECTS  = 16,
    parameter int COORD_BITS = 12
) (
    input  logic         aclk,
    input  logic         aresetn,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    // rect_left, rect_top, rect_width, rect_height, pixel_row, pixel_column, zero pad
    input  logic [((54 + 2*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    // in_mask, zero pad
    output logic [7:0]   m_tdata
);

    localparam int TOP_LSB = 13;
    localparam int WID_LSB = 26;
    localparam int HGT_LSB = 40;
    localparam int ROW_LSB = 54;
    localparam int COL_LSB = 54 + COORD_BITS;

    logic [DIM_W-1:0] cols_reg;
    logic [DIM_W-1:0] rows_reg;
    logic             m_valid_reg;
    logic             mask_reg;
    logic             advance;
    beat_t            chain [0:MAX_RECTS];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_COLS) begin
                cols_reg <= pwdata[DIM_W-1:0];
            end else begin
                rows_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROWS) ? {{(32-DIM_W){1'b0}}, rows_reg}
                                           : {{(32-DIM_W){1'b0}}, cols_reg};

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    roi_entry #(
        .COORD_BITS (COORD_BITS)
    ) u_entry (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .load          (s_tvalid),
        .command       (s_tuser),
        .rect_left     (s_tdata[TOP_LSB-1:0]),
        .rect_top      (s_tdata[WID_LSB-1:TOP_LSB]),
        .rect_width    (s_tdata[HGT_LSB-1:WID_LSB]),
        .rect_height   (s_tdata[ROW_LSB-1:HGT_LSB]),
        .pixel_row     (s_tdata[COL_LSB-1:ROW_LSB]),
        .pixel_column  (s_tdata[COL_LSB+COORD_BITS-1:COL_LSB]),
        .image_columns (cols_reg),
        .image_rows    (rows_reg),
        .beat          (chain[0])
    );

    for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
        roi_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= (chain[MAX_RECTS].kind == CMD_QUERY);
            mask_reg    <= chain[MAX_RECTS].hit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0000000, mask_reg};

endmodule
